// ----- rtl/crs_pkg.sv -----
// Shared types, constants and sizes for the cubic fractional resampler.
package crs_pkg;

	localparam int SAMPLE_BITS      = 24;
	localparam int FRAC_BITS        = 24;
	localparam int STEP_BITS        = 28;
	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int MAX_RESULTS      = 16;
	localparam int COUNT_BITS       = 5;
	localparam int NEED_BITS        = 5;
	localparam int POP_BITS         = STEP_BITS - FRAC_BITS + 1;
	localparam int TAPS             = 4;
	localparam int JOB_DEPTH        = 2;
	localparam int RES_DEPTH        = 4;
	localparam int ACC_BITS         = SAMPLE_BITS + 6;
	localparam int TMUL_BITS        = FRAC_BITS + 1;
	localparam int PROD_BITS        = ACC_BITS + TMUL_BITS;

	localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = STEP_BITS'(1) << FRAC_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;

	typedef struct packed {
		sample_t in_left;
		sample_t in_right;
	} in_item_t;

	typedef struct packed {
		sample_t out_left;
		sample_t out_right;
		logic    last;
	} out_item_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} stereo_t;

	// One interpolation job: four oldest window samples, fraction and end mark
	typedef struct packed {
		stereo_t [TAPS-1:0]   x;
		logic [FRAC_BITS-1:0] t;
		logic                 last;
	} job_t;

endpackage

// ----- rtl/crs_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module crs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/crs_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
module crs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// hold the beat payloads
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/crs_front.sv -----
// Front end: window store, phase and fill tracking, interpolation job issue.
module crs_front #(
	parameter int WINDOW_DEPTH = crs_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  crs_pkg::in_item_t              in_item,
	input  logic                           step_we,
	input  logic [crs_pkg::STEP_BITS-1:0]  step_wdata,
	output logic                           job_push,
	input  logic                           job_full,
	output crs_pkg::job_t                  job
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int CW = (FW > crs_pkg::NEED_BITS) ? FW : crs_pkg::NEED_BITS;
	localparam int SW = 2 * crs_pkg::SAMPLE_BITS;

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_CHECK = 5'b00010,
		F_READ  = 5'b00100,
		F_WAIT  = 5'b01000,
		F_PUSH  = 5'b10000
	} fstate_t;

	fstate_t                             state_q;
	logic [AW-1:0]                       head_q;
	logic [FW-1:0]                       fill_q;
	logic [crs_pkg::FRAC_BITS-1:0]       phase_q;
	logic [crs_pkg::STEP_BITS-1:0]       step_q;
	logic [crs_pkg::COUNT_BITS-1:0]      n_q;
	logic [1:0]                          rd_q;
	logic                                cap_v_s1;
	logic [1:0]                          cap_idx_s1;
	crs_pkg::stereo_t [crs_pkg::TAPS-1:0] x_q;

	logic [crs_pkg::NEED_BITS-1:0]       units;
	logic [crs_pkg::NEED_BITS-1:0]       need;
	logic [crs_pkg::STEP_BITS:0]         ph;
	logic [crs_pkg::POP_BITS-1:0]        pops;
	logic [FW-1:0]                       fill_nx;
	logic                                cont;
	logic                                go_first;
	logic                                win_full;
	logic                                accept;
	logic                                ram_we;
	logic [AW-1:0]                       ram_waddr;
	logic [SW-1:0]                       ram_wdata;
	logic                                ram_re;
	logic [AW-1:0]                       ram_raddr;
	logic [SW-1:0]                       ram_rdata;

	// circular index: base plus offset, offset never beyond the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [AW:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + off;
		if (sum >= (AW+1)'(WINDOW_DEPTH)) begin
			sum = sum - (AW+1)'(WINDOW_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// samples needed before a result: ceil(step) but at least one, plus three
	always_comb begin
		units = crs_pkg::NEED_BITS'(step_q[crs_pkg::STEP_BITS-1:crs_pkg::FRAC_BITS])
			+ crs_pkg::NEED_BITS'(|step_q[crs_pkg::FRAC_BITS-1:0]);
		need = ((units == '0) ? crs_pkg::NEED_BITS'(1) : units)
			+ crs_pkg::NEED_BITS'(crs_pkg::TAPS - 1);
	end

	// phase advance and whole-sample drop for the job in hand
	always_comb begin
		ph       = (crs_pkg::STEP_BITS+1)'(phase_q) + (crs_pkg::STEP_BITS+1)'(step_q);
		pops     = ph[crs_pkg::STEP_BITS:crs_pkg::FRAC_BITS];
		fill_nx  = fill_q - FW'(pops);
		cont     = (n_q < crs_pkg::COUNT_BITS'(crs_pkg::MAX_RESULTS - 1))
			&& (CW'(fill_nx) >= CW'(need));
		go_first = (CW'(fill_q) >= CW'(need));
	end

	assign full     = (state_q != F_IDLE);
	assign accept   = push && (state_q == F_IDLE);
	assign win_full = (fill_q == FW'(WINDOW_DEPTH));

	// window write on accept: append, or overwrite the oldest when full
	assign ram_we    = accept;
	assign ram_waddr = win_full ? head_q : wrap_add(head_q, (AW+1)'(fill_q));
	assign ram_wdata = {in_item.in_left, in_item.in_right};
	assign ram_re    = (state_q == F_READ);
	assign ram_raddr = wrap_add(head_q, (AW+1)'(rd_q));

	crs_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// job beat to the back end
	assign job_push = (state_q == F_PUSH) && !job_full;
	always_comb begin
		job.x    = x_q;
		job.t    = phase_q;
		job.last = !cont;
	end

	// sequencer and window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			head_q   <= '0;
			fill_q   <= '0;
			phase_q  <= '0;
			step_q   <= crs_pkg::PHASE_STEP_RESET;
			n_q      <= '0;
			rd_q     <= '0;
			cap_v_s1 <= 1'b0;
		end else begin
			cap_v_s1 <= (state_q == F_READ);
			if (step_we) begin
				step_q <= step_wdata;
			end
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						if (win_full) begin
							head_q <= wrap_add(head_q, (AW+1)'(1));
						end else begin
							fill_q <= fill_q + FW'(1);
						end
						n_q     <= '0;
						state_q <= F_CHECK;
					end
				end
				F_CHECK: begin
					rd_q    <= '0;
					state_q <= go_first ? F_READ : F_IDLE;
				end
				F_READ: begin
					rd_q <= rd_q + 2'd1;
					if (rd_q == 2'(crs_pkg::TAPS - 1)) begin
						state_q <= F_WAIT;
					end
				end
				F_WAIT: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!job_full) begin
						phase_q <= ph[crs_pkg::FRAC_BITS-1:0];
						head_q  <= wrap_add(head_q, (AW+1)'(pops));
						fill_q  <= fill_nx;
						n_q     <= n_q + crs_pkg::COUNT_BITS'(1);
						rd_q    <= '0;
						state_q <= cont ? F_READ : F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// capture the four taps as they come out of the window
	always_ff @(posedge clk) begin
		cap_idx_s1 <= rd_q;
		if (cap_v_s1) begin
			x_q[cap_idx_s1] <= crs_pkg::stereo_t'(ram_rdata);
		end
	end

endmodule

// ----- rtl/crs_back.sv -----
// Back end: Catmull-Rom evaluation of one job at a time in three passes, one multiplier per channel.
module crs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	output logic                job_pop,
	input  crs_pkg::job_t       job,
	input  logic                res_full,
	output logic                res_push,
	output crs_pkg::out_item_t  res
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_COEF = 5'b00010,
		B_MUL  = 5'b00100,
		B_ACC  = 5'b01000,
		B_FIN  = 5'b10000
	} bstate_t;

	localparam crs_pkg::acc_t YMAX = crs_pkg::acc_t'(2 ** (crs_pkg::SAMPLE_BITS - 1) - 1);
	localparam crs_pkg::acc_t YMIN = -YMAX - crs_pkg::acc_t'(1);
	localparam crs_pkg::prod_t HALF = crs_pkg::prod_t'(1) <<< (crs_pkg::FRAC_BITS - 1);

	bstate_t              state_q;
	logic [1:0]           pass_q;
	crs_pkg::job_t        job_q;
	crs_pkg::acc_t        acc_q  [2];
	crs_pkg::acc_t        b_q    [2];
	crs_pkg::acc_t        c_q    [2];
	crs_pkg::prod_t       prod_q [2];

	crs_pkg::acc_t        e      [2][crs_pkg::TAPS];
	crs_pkg::acc_t        coef_a [2];
	crs_pkg::acc_t        coef_b [2];
	crs_pkg::acc_t        coef_c [2];
	crs_pkg::acc_t        acc_nx [2];
	crs_pkg::acc_t        ysat   [2];
	logic signed [crs_pkg::TMUL_BITS-1:0] tm;

	assign tm = {1'b0, job_q.t};

	// widen the taps of both channels
	always_comb begin
		for (int k = 0; k < crs_pkg::TAPS; k++) begin
			e[0][k] = crs_pkg::acc_t'(job_q.x[k].left);
			e[1][k] = crs_pkg::acc_t'(job_q.x[k].right);
		end
	end

	// doubled Catmull-Rom coefficients, rounding step and output saturation
	always_comb begin
		crs_pkg::prod_t rnd;
		crs_pkg::acc_t  r1;
		crs_pkg::acc_t  y;
		for (int ch = 0; ch < 2; ch++) begin
			coef_a[ch] = e[ch][3] - e[ch][0] + (e[ch][1] <<< 1) + e[ch][1]
				- (e[ch][2] <<< 1) - e[ch][2];
			coef_b[ch] = (e[ch][0] <<< 1) - (e[ch][1] <<< 2) - e[ch][1]
				+ (e[ch][2] <<< 2) - e[ch][3];
			coef_c[ch] = e[ch][2] - e[ch][0];

			rnd = (prod_q[ch] + HALF) >>> crs_pkg::FRAC_BITS;
			case (pass_q)
				2'd0:    acc_nx[ch] = crs_pkg::acc_t'(rnd[crs_pkg::ACC_BITS-1:0]) + b_q[ch];
				2'd1:    acc_nx[ch] = crs_pkg::acc_t'(rnd[crs_pkg::ACC_BITS-1:0]) + c_q[ch];
				default: acc_nx[ch] = crs_pkg::acc_t'(rnd[crs_pkg::ACC_BITS-1:0]);
			endcase

			r1 = (acc_q[ch] + crs_pkg::acc_t'(1)) >>> 1;
			y  = e[ch][1] + r1;
			if (y > YMAX) begin
				ysat[ch] = YMAX;
			end else if (y < YMIN) begin
				ysat[ch] = YMIN;
			end else begin
				ysat[ch] = y;
			end
		end
	end

	assign job_pop  = (state_q == B_IDLE) && !job_empty;
	assign res_push = (state_q == B_FIN) && !res_full;
	always_comb begin
		res.out_left  = crs_pkg::sample_t'(ysat[0][crs_pkg::SAMPLE_BITS-1:0]);
		res.out_right = crs_pkg::sample_t'(ysat[1][crs_pkg::SAMPLE_BITS-1:0]);
		res.last      = job_q.last;
	end

	// sequencer: coefficients, then three multiply and accumulate passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pass_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						state_q <= B_COEF;
					end
				end
				B_COEF: begin
					pass_q  <= '0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					state_q <= B_ACC;
				end
				B_ACC: begin
					if (pass_q == 2'd2) begin
						state_q <= B_FIN;
					end else begin
						pass_q  <= pass_q + 2'd1;
						state_q <= B_MUL;
					end
				end
				B_FIN: begin
					if (!res_full) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		for (int ch = 0; ch < 2; ch++) begin
			if (state_q == B_COEF) begin
				acc_q[ch] <= coef_a[ch];
				b_q[ch]   <= coef_b[ch];
				c_q[ch]   <= coef_c[ch];
			end
			if (state_q == B_MUL) begin
				prod_q[ch] <= acc_q[ch] * tm;
			end
			if (state_q == B_ACC) begin
				acc_q[ch] <= acc_nx[ch];
			end
		end
	end

endmodule

// ----- rtl/cubic_fractional_resampler.sv -----
// Top level: stereo Catmull-Rom resampler, window front end, job queue, evaluator.
// The evaluator handles one job at a time with a single multiplier
// per channel, which runs three multiply and round passes for each result.
// The input side stays busy until every job of an accepted sample is queued; when
// the job queue fills, the evaluator paces it.
// Reset: asynchronous, clears the window fill, head, phase and queues; step is 1.0.
module cubic_fractional_resampler #(
	parameter int WINDOW_DEPTH = crs_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  crs_pkg::in_item_t              in_item,
	input  logic                           phase_step_we,
	input  logic [crs_pkg::STEP_BITS-1:0]  phase_step_wdata,
	output logic                           empty,
	input  logic                           pop,
	output crs_pkg::out_item_t             out_item
);

	localparam int JW = $bits(crs_pkg::job_t);
	localparam int RW = $bits(crs_pkg::out_item_t);

	logic               job_push;
	logic               job_full;
	logic               job_pop;
	logic               job_empty;
	crs_pkg::job_t      job_in;
	logic [JW-1:0]      job_rdata;
	logic               res_push;
	logic               res_full;
	crs_pkg::out_item_t res_in;
	logic [RW-1:0]      res_rdata;

	crs_front #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.step_we    (phase_step_we),
		.step_wdata (phase_step_wdata),
		.job_push   (job_push),
		.job_full   (job_full),
		.job        (job_in)
	);

	crs_fifo #(
		.WIDTH (JW),
		.DEPTH (crs_pkg::JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.full   (job_full),
		.wdata  (job_in),
		.pop    (job_pop),
		.empty  (job_empty),
		.rdata  (job_rdata)
	);

	crs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job       (crs_pkg::job_t'(job_rdata)),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	crs_fifo #(
		.WIDTH (RW),
		.DEPTH (crs_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_rdata)
	);

	assign out_item = crs_pkg::out_item_t'(res_rdata);

endmodule

// ----- rtl/crs_checker.sv -----
// Port-level checks for the cubic fractional resampler, bound to the top level.
module crs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input crs_pkg::out_item_t            out_item
);

	logic [2:0]                     in_cnt_q;
	logic [crs_pkg::COUNT_BITS-1:0] run_q;

	// count accepted inputs up to four, and results since the last end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q <= '0;
			run_q    <= '0;
		end else begin
			if (push && !full && in_cnt_q != 3'(crs_pkg::TAPS)) begin
				in_cnt_q <= in_cnt_q + 3'd1;
			end
			if (pop && !empty) begin
				run_q <= out_item.last ? '0 : run_q + crs_pkg::COUNT_BITS'(1);
			end
		end
	end

	// a waiting result beat holds until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result beat changed before pop");

	// an accepted sample keeps the input side busy the next cycle
	a_busy_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("input side free right after an accepted beat");

	// no result before the window has four samples
	a_four_taps: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> in_cnt_q == 3'(crs_pkg::TAPS))
		else $error("result shown before four samples were accepted");

	// at most sixteen results per input, the sixteenth carries the end mark
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !out_item.last
			|-> run_q < crs_pkg::COUNT_BITS'(crs_pkg::MAX_RESULTS - 1))
		else $error("result run longer than allowed without end mark");

endmodule

bind cubic_fractional_resampler crs_checker u_checker (.*);
